/* src/mctt_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker package
// Shared widths, constants and the sequencer state type.
// ----------------------------------------------------------------------------
package mctt_pkg;

  // Width of the shared serial divider.
  localparam int unsigned DivW = 24;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  localparam int unsigned TicksPerQuarter = 24;

  localparam logic [8:0]  MinBpm      = 9'd20;
  localparam logic [8:0]  MaxBpm      = 9'd300;
  localparam logic [31:0] MinInterval = 32'd200;
  localparam logic [31:0] MaxInterval = 32'd3000;
  localparam logic [31:0] RateLimitMs = 32'd500;

  // Average thresholds in Q12.8 milliseconds.
  localparam logic [19:0] AvgFast = 20'(300 * 256);
  localparam logic [19:0] AvgSlow = 20'(1000 * 256);

  // 60000 ms per minute, scaled by 256 for the Q12.8 average.
  localparam logic [DivW-1:0] BpmNumerator = DivW'(60000 * 256);
  localparam logic [DivW-1:0] MsPerMinute  = DivW'(60000);

  // Configuration register indexes.
  localparam logic [2:0] CfgSrcEn     = 3'd0;
  localparam logic [2:0] CfgDeadzone  = 3'd1;
  localparam logic [2:0] CfgDivider   = 3'd2;
  localparam logic [2:0] CfgBeatsBar  = 3'd3;
  localparam logic [2:0] CfgLedEn     = 3'd4;
  localparam logic [2:0] CfgEmphasize = 3'd5;
  localparam logic [2:0] CfgPercent   = 3'd6;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_QTR  = 11'b00000000010,
    S_AVG  = 11'b00000000100,
    S_D10  = 11'b00000001000,
    S_BPM  = 11'b00000010000,
    S_DB   = 11'b00000100000,
    S_DEC  = 11'b00001000000,
    S_BEAT = 11'b00010000000,
    S_F1   = 11'b00100000000,
    S_F2   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

endpackage

/* src/mctt_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mctt_div import mctt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic [DivW:0]      rem_q;
  logic [DivW-1:0]    quo_q;
  logic [DivW-1:0]    dsr_q;
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;

  logic [DivW:0] shifted;
  logic [DivW:0] diff;

  // One trial subtraction per cycle.
  assign shifted = {rem_q[DivW-1:0], quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  // Control counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DivCntW'(DivW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - DivCntW'(1);
      done_q <= (cnt_q == DivCntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!diff[DivW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/midi_clock_tempo_tracker_core.sv */
// Up to four divisions per tick run in the shared one-bit-per-cycle divider: the
// average blend, the BPM and, for a flash, the beat length and its percentage.
// One tick is processed at a time; the next is accepted once the result is
// registered and the sequencer is back in idle. Reset is asynchronous and active
// low; it restores the configuration, control and tracking state, while the
// working and result payload registers are not reset.
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker core
// Averages quarter-note intervals into a tempo and produces beat and LED events.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker_core import mctt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ms_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tempo_changed_o,
  output logic [8:0]  bpm_o,
  output logic        beat_o,
  output logic [4:0]  bar_pos_o,
  output logic        flash_o,
  output logic [9:0]  flash_length_ms_o
);

  // Configuration registers.
  logic       src_en_q, led_en_q, emph_q;
  logic [2:0] deadzone_q;
  logic [6:0] divider_q;
  logic [4:0] bpb_q;
  logic [3:0] percent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_en_q   <= 1'b1;
      deadzone_q <= 3'd0;
      divider_q  <= 7'd24;
      bpb_q      <= 5'd4;
      led_en_q   <= 1'b0;
      emph_q     <= 1'b1;
      percent_q  <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSrcEn:     src_en_q   <= cfg_wdata_i[0];
        CfgDeadzone:  deadzone_q <= cfg_wdata_i[2:0];
        CfgDivider:   divider_q  <= cfg_wdata_i[6:0];
        CfgBeatsBar:  bpb_q      <= cfg_wdata_i[4:0];
        CfgLedEn:     led_en_q   <= cfg_wdata_i[0];
        CfgEmphasize: emph_q     <= cfg_wdata_i[0];
        CfgPercent:   percent_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Tracking state.
  state_e      state_q, state_d;
  logic [4:0]  qphase_q, qphase_d;
  logic [6:0]  dphase_q, dphase_d;
  logic [31:0] lqt_q, lqt_d;
  logic [19:0] avg_q, avg_d;
  logic        avg_valid_q, avg_valid_d;
  logic [31:0] lut_q, lut_d;
  logic [8:0]  cur_q, cur_d;
  logic [4:0]  bcount_q, bcount_d;

  // Per-transaction working registers.
  logic [31:0] now_q, now_d;
  logic [11:0] ival_q, ival_d;
  logic [8:0]  nb_q, nb_d;
  logic        chg_q, chg_d;
  logic        beat_q, beat_d;
  logic [4:0]  pos_q, pos_d;
  logic        flash_q, flash_d;
  logic [9:0]  flen_q, flen_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        o_chg_q, o_chg_d, o_beat_q, o_beat_d, o_flash_q, o_flash_d;
  logic [8:0]  o_bpm_q, o_bpm_d;
  logic [4:0]  o_pos_q, o_pos_d;
  logic [9:0]  o_flen_q, o_flen_d;

  // Shared divider.
  logic            div_start;
  logic [DivW-1:0] div_dvd, div_dsr, div_quo;
  logic            div_done;

  mctt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic        in_acc;
  logic [31:0] ival_full, since_upd;
  logic [19:0] iq;
  logic [22:0] e4, e6, iq5;
  logic [23:0] blend;
  logic [7:0]  div_eff, dphase_inc;
  logic [5:0]  bcount_inc;
  logic [8:0]  delta;
  logic [15:0] prod;

  assign in_acc = in_valid_i && !in_stall_o;

  // Arithmetic helpers, each used by one sequencer state.
  always_comb begin
    ival_full  = now_q - lqt_q;
    since_upd  = now_q - lut_q;
    iq         = {ival_q, 8'd0};
    e4         = {1'b0, avg_q, 2'b00};
    e6         = {1'b0, avg_q, 2'b00} + {2'b00, avg_q, 1'b0};
    iq5        = {1'b0, iq, 2'b00} + {3'b000, iq};
    div_eff    = (divider_q == 7'd0) ? 8'd1 : {1'b0, divider_q};
    dphase_inc = {1'b0, dphase_q} + 8'd1;
    bcount_inc = {1'b0, bcount_q} + 6'd1;
    delta      = (nb_q > cur_q) ? (nb_q - cur_q) : (cur_q - nb_q);
    prod       = {4'd0, div_quo[11:0]} * {12'd0, percent_q};
    // Alpha of 0.5, 0.3 or 0.4 by tempo; rounding constant of 5 tenths.
    if (avg_q < AvgFast) begin
      blend = 24'(5) * {4'd0, iq} + 24'(5) * {4'd0, avg_q} + 24'd5;
    end else if (avg_q > AvgSlow) begin
      blend = 24'(3) * {4'd0, iq} + 24'(7) * {4'd0, avg_q} + 24'd5;
    end else begin
      blend = 24'(4) * {4'd0, iq} + 24'(6) * {4'd0, avg_q} + 24'd5;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    qphase_d    = qphase_q;
    dphase_d    = dphase_q;
    lqt_d       = lqt_q;
    avg_d       = avg_q;
    avg_valid_d = avg_valid_q;
    lut_d       = lut_q;
    cur_d       = cur_q;
    bcount_d    = bcount_q;
    now_d       = now_q;
    ival_d      = ival_q;
    nb_d        = nb_q;
    chg_d       = chg_q;
    beat_d      = beat_q;
    pos_d       = pos_q;
    flash_d     = flash_q;
    flen_d      = flen_q;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dsr     = '0;
    out_valid_d = out_valid_q && out_stall_i;
    o_chg_d     = o_chg_q;
    o_bpm_d     = o_bpm_q;
    o_beat_d    = o_beat_q;
    o_pos_d     = o_pos_q;
    o_flash_d   = o_flash_q;
    o_flen_d    = o_flen_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          now_d   = now_ms_i;
          chg_d   = 1'b0;
          beat_d  = 1'b0;
          pos_d   = '0;
          flash_d = 1'b0;
          flen_d  = '0;
          state_d = src_en_q ? S_QTR : S_OUT;
        end
      end
      S_QTR: begin
        state_d = S_BEAT;
        if ({27'd0, qphase_q} + 32'd1 >= 32'(TicksPerQuarter)) begin
          qphase_d = '0;
          lqt_d    = now_q;
          if (lqt_q != '0 && ival_full >= MinInterval && ival_full <= MaxInterval) begin
            ival_d  = ival_full[11:0];
            state_d = S_AVG;
          end
        end else begin
          qphase_d = qphase_q + 5'd1;
        end
      end
      S_AVG: begin
        avg_valid_d = 1'b1;
        if (avg_valid_q && e4 <= iq5 && iq5 <= e6) begin
          div_start = 1'b1;
          div_dvd   = blend;
          div_dsr   = DivW'(10);
          state_d   = S_D10;
        end else begin
          avg_d   = iq;
          state_d = S_BPM;
        end
      end
      S_D10: begin
        if (div_done) begin
          avg_d   = div_quo[19:0];
          state_d = S_BPM;
        end
      end
      S_BPM: begin
        if (avg_q == '0) begin
          nb_d    = MaxBpm;
          state_d = S_DEC;
        end else begin
          div_start = 1'b1;
          div_dvd   = BpmNumerator;
          div_dsr   = {4'd0, avg_q};
          state_d   = S_DB;
        end
      end
      S_DB: begin
        if (div_done) begin
          if (div_quo > DivW'(MaxBpm)) begin
            nb_d = MaxBpm;
          end else if (div_quo < DivW'(MinBpm)) begin
            nb_d = MinBpm;
          end else begin
            nb_d = div_quo[8:0];
          end
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (delta > {6'd0, deadzone_q} && (lut_q == '0 || since_upd >= RateLimitMs)) begin
          cur_d = nb_q;
          lut_d = now_q;
          chg_d = 1'b1;
        end
        state_d = S_BEAT;
      end
      S_BEAT: begin
        state_d = S_OUT;
        if (dphase_inc >= div_eff) begin
          dphase_d = '0;
          beat_d   = 1'b1;
          if (bcount_inc > {1'b0, bpb_q}) begin
            bcount_d = 5'd1;
          end else begin
            bcount_d = bcount_inc[4:0];
          end
          pos_d = bcount_d;
          if (led_en_q) begin
            div_start = 1'b1;
            div_dvd   = MsPerMinute;
            div_dsr   = (cur_q == '0) ? DivW'(1) : {15'd0, cur_q};
            state_d   = S_F1;
          end
        end else begin
          dphase_d = dphase_inc[6:0];
        end
      end
      S_F1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = {8'd0, prod};
          div_dsr   = DivW'(100);
          state_d   = S_F2;
        end
      end
      S_F2: begin
        if (div_done) begin
          flash_d = 1'b1;
          // Doubling on the downbeat keeps the low ten bits.
          if (emph_q && bcount_q == 5'd1) begin
            flen_d = {div_quo[8:0], 1'b0};
          end else begin
            flen_d = div_quo[9:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Load the result once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_chg_d     = chg_q;
          o_bpm_d     = cur_q;
          o_beat_d    = beat_q;
          o_pos_d     = pos_q;
          o_flash_d   = flash_q;
          o_flen_d    = flen_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      qphase_q    <= '0;
      dphase_q    <= '0;
      lqt_q       <= '0;
      avg_q       <= '0;
      avg_valid_q <= 1'b0;
      lut_q       <= '0;
      cur_q       <= 9'd120;
      bcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qphase_q    <= qphase_d;
      dphase_q    <= dphase_d;
      lqt_q       <= lqt_d;
      avg_q       <= avg_d;
      avg_valid_q <= avg_valid_d;
      lut_q       <= lut_d;
      cur_q       <= cur_d;
      bcount_q    <= bcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    ival_q    <= ival_d;
    nb_q      <= nb_d;
    chg_q     <= chg_d;
    beat_q    <= beat_d;
    pos_q     <= pos_d;
    flash_q   <= flash_d;
    flen_q    <= flen_d;
    o_chg_q   <= o_chg_d;
    o_bpm_q   <= o_bpm_d;
    o_beat_q  <= o_beat_d;
    o_pos_q   <= o_pos_d;
    o_flash_q <= o_flash_d;
    o_flen_q  <= o_flen_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign tempo_changed_o   = o_chg_q;
  assign bpm_o             = o_bpm_q;
  assign beat_o            = o_beat_q;
  assign bar_pos_o         = o_pos_q;
  assign flash_o           = o_flash_q;
  assign flash_length_ms_o = o_flen_q;

  // The tracked tempo never leaves the clamped range.
  a_bpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q >= MinBpm && cur_q <= MaxBpm)
    else $error("tempo outside clamped range");

  // A beat position is reported exactly on beats.
  a_pos_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((o_pos_q != '0) == o_beat_q))
    else $error("beat position without beat");

  // A flash comes only with a beat, and a length only with a flash.
  a_flash_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!o_flash_q || o_beat_q) && (o_flash_q || o_flen_q == '0)))
    else $error("flash outside a beat");

  // The divider is only started from an idle unit.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_done)
    else $error("divider done too early");

endmodule

/* tb/midi_clock_tempo_tracker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI clock tempo tracker core testbench
// Drives streams of timestamped clock ticks through the core under random
// handshake pressure and several register settings, and checks every result
// transaction against a directed value or a cycle-free tempo predictor in the bench.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker_core_tb;
  import mctt_pkg::*;

  typedef struct packed {
    logic       changed;
    logic [8:0] bpm;
    logic       beat;
    logic [4:0] pos;
    logic       flash;
    logic [9:0] flen;
  } tick_result_t;

  typedef struct {
    logic [31:0]  now;
    bit           typed;
    tick_result_t res;
  } tick_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        tempo_changed_o;
  logic [8:0]  bpm_o;
  logic        beat_o;
  logic [4:0]  bar_pos_o;
  logic        flash_o;
  logic [9:0]  flash_length_ms_o;

  midi_clock_tempo_tracker_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .now_ms_i,
    .out_valid_o, .out_stall_i, .tempo_changed_o, .bpm_o,
    .beat_o, .bar_pos_o, .flash_o, .flash_length_ms_o
  );

  always #5 clk_i = ~clk_i;

  // Generous overall limit on the run.
  initial begin
    #50_000_000;
    $display("[midi_clock_tempo_tracker_core] ERROR");
    $finish;
  end

  // Shadow registers and tracking state of the predictor.
  logic        src_en, led_en, emph;
  logic [2:0]  deadzone;
  logic [6:0]  divider;
  logic [4:0]  beats_bar;
  logic [3:0]  percent;
  logic [31:0] qtr_phase, div_phase, last_qtr_t, avg_q8, last_upd_t, bpm_now, beat_cnt;
  logic        avg_ok;

  tick_result_t expected_ticks[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Reset values of the registers and of the tracking state.
  task automatic predictor_reset();
    src_en = 1'b1; deadzone = 3'd0; divider = 7'd24; beats_bar = 5'd4;
    led_en = 1'b0; emph = 1'b1; percent = 4'd3;
    qtr_phase = 0; div_phase = 0; last_qtr_t = 0; avg_q8 = 0; avg_ok = 1'b0;
    last_upd_t = 0; bpm_now = 120; beat_cnt = 0;
  endtask

  // Fold a measured quarter interval into the Q12.8 average.
  function automatic void fold_interval(logic [31:0] ival);
    logic [31:0] iq, a;
    iq = ival * 256;
    if (!avg_ok) begin
      avg_q8 = iq;
      avg_ok = 1'b1;
    end else if (4 * avg_q8 <= 5 * iq && 5 * iq <= 6 * avg_q8) begin
      if (avg_q8 < 300 * 256) a = 5;
      else if (avg_q8 > 1000 * 256) a = 3;
      else a = 4;
      avg_q8 = (a * iq + (10 - a) * avg_q8 + 5) / 10;
    end else begin
      avg_q8 = iq;
    end
    avg_q8 &= 32'hFFFFF;
  endfunction

  // Work out the result of one accepted tick and advance the tracking state.
  function automatic tick_result_t tempo_predict(logic [31:0] now);
    tick_result_t r;
    logic [31:0] ival, nb, delta, dv, b, fl;
    r = '0;
    if (src_en) begin
      qtr_phase++;
      if (qtr_phase >= TicksPerQuarter) begin
        qtr_phase = 0;
        if (last_qtr_t != 0) begin
          ival = now - last_qtr_t;
          if (ival >= 200 && ival <= 3000) begin
            fold_interval(ival);
            if (avg_q8 == 0) nb = 300;
            else nb = (60000 * 256) / avg_q8;
            if (nb < 20) nb = 20;
            if (nb > 300) nb = 300;
            delta = nb > bpm_now ? nb - bpm_now : bpm_now - nb;
            if (delta > deadzone && (last_upd_t == 0 || now - last_upd_t >= 500)) begin
              bpm_now = nb;
              last_upd_t = now;
              r.changed = 1'b1;
            end
          end
        end
        last_qtr_t = now;
      end
      dv = divider == 0 ? 1 : divider;
      div_phase++;
      if (div_phase >= dv) begin
        div_phase = 0;
        r.beat = 1'b1;
        beat_cnt++;
        if (beat_cnt > beats_bar) beat_cnt = 1;
        beat_cnt &= 32'h1F;
        r.pos = beat_cnt[4:0];
        if (led_en) begin
          b = bpm_now == 0 ? 1 : bpm_now;
          fl = ((60000 / b) * percent) / 100;
          if (emph && beat_cnt == 1) fl *= 2;
          r.flen = fl[9:0];
          r.flash = 1'b1;
        end
      end
    end
    r.bpm = bpm_now[8:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 100)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Result side: random stall and field-by-field comparison.
  always @(posedge clk_i) begin
    tick_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = expected_ticks.pop_front();
        if (tempo_changed_o !== e.changed)
          report_mismatch("tempo_changed", tempo_changed_o, e.changed);
        if (bpm_o !== e.bpm) report_mismatch("bpm", bpm_o, e.bpm);
        if (beat_o !== e.beat) report_mismatch("beat", beat_o, e.beat);
        if (bar_pos_o !== e.pos) report_mismatch("bar_pos", bar_pos_o, e.pos);
        if (flash_o !== e.flash) report_mismatch("flash", flash_o, e.flash);
        if (flash_length_ms_o !== e.flen)
          report_mismatch("flash_length_ms", flash_length_ms_o, e.flen);
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Register write on the configuration port; the shadow copy follows it.
  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgSrcEn:     src_en = val[0];
      CfgDeadzone:  deadzone = val[2:0];
      CfgDivider:   divider = val;
      CfgBeatsBar:  beats_bar = val[4:0];
      CfgLedEn:     led_en = val[0];
      CfgEmphasize: emph = val[0];
      CfgPercent:   percent = val[3:0];
      default: ;
    endcase
  endtask

  // Let the core drain completely before touching the registers.
  task automatic wait_drained();
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Offer one tick, hold it until accepted, then maybe leave a gap.
  task automatic send_tick(logic [31:0] t, bit typed, tick_result_t want);
    tick_result_t p;
    in_valid_i <= 1'b1;
    now_ms_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    p = tempo_predict(t);
    expected_ticks.push_back(typed ? want : p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [6:0] pick_field(int hi, int lo_ext, int hi_ext);
    case ($urandom_range(0, 3))
      0: return lo_ext[6:0];
      1: return hi_ext[6:0];
      default: return 7'($urandom_range(0, hi));
    endcase
  endfunction

  tick_row_t   tick_table[$];
  tick_result_t r;
  logic [31:0] clock_t, q_ms;
  int          counted, phase_len, k;

  initial begin
    predictor_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: one beat per tick, three beats per bar, ten-percent flashes.
    write_reg(CfgDivider, 7'd1);
    write_reg(CfgBeatsBar, 7'd3);
    write_reg(CfgLedEn, 7'd1);
    write_reg(CfgPercent, 7'd10);
    write_reg(CfgEmphasize, 7'd1);
    // At 120 BPM a beat lasts 500 ms, so 10 percent is 50 ms, doubled on beat one.
    r = '{changed: 0, bpm: 120, beat: 1, pos: 1, flash: 1, flen: 100};
    tick_table.push_back('{32'd0, 1, r});
    r.pos = 2; r.flen = 50;
    tick_table.push_back('{32'hFFFF_FFFF, 1, r});
    r.pos = 3;
    tick_table.push_back('{32'h8000_0000, 1, r});
    r.pos = 1; r.flen = 100;
    tick_table.push_back('{32'h0000_0001, 1, r});
    // Remaining ticks lead up to the first quarter, which only records its time.
    for (int i = 0; i < 20; i++)
      tick_table.push_back('{(i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA, 0, '0});
    foreach (tick_table[i]) send_tick(tick_table[i].now, tick_table[i].typed, tick_table[i].res);
    in_valid_i <= 1'b0;

    // Random part: phases of steady clock streams with occasional noise.
    counted = 0;
    clock_t = 32'd1000;
    while (counted < 1900) begin
      wait_drained();
      send_idle_pct = counted < 630 ? 19 : (counted < 1260 ? 60 : 0);
      recv_stall_pct = counted < 630 ? 60 : (counted < 1260 ? 19 : 0);
      write_reg(CfgSrcEn, ($urandom_range(0, 99) < 12) ? 7'd0 : 7'd1);
      write_reg(CfgDeadzone, pick_field(7, 0, 7));
      write_reg(CfgDivider, pick_field(127, 0, $urandom_range(0, 1) ? 96 : 127));
      write_reg(CfgBeatsBar, pick_field(31, $urandom_range(0, 1), $urandom_range(0, 1) ? 16 : 31));
      write_reg(CfgLedEn, 7'($urandom_range(0, 1)));
      write_reg(CfgEmphasize, 7'($urandom_range(0, 1)));
      write_reg(CfgPercent, pick_field(15, $urandom_range(0, 1), $urandom_range(0, 1) ? 10 : 15));
      case ($urandom_range(0, 3))
        0: clock_t = 32'hFFFF_F000 + $urandom_range(0, 3000);
        1: clock_t = $urandom;
        default: ;
      endcase
      q_ms = $urandom_range(150, 3200);
      phase_len = $urandom_range(40, 150);
      for (k = 0; k < phase_len; k++) begin
        // Tempo drifts gently, now and then jumps, and rarely a tick is garbage.
        case ($urandom_range(0, 199))
          0, 1:    q_ms = $urandom_range(150, 3200);
          2, 3, 4: q_ms = q_ms + $urandom_range(0, q_ms / 8) - q_ms / 16;
          default: ;
        endcase
        if ($urandom_range(0, 99) < 4)
          send_tick(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, 0, '0);
        else begin
          clock_t = clock_t + q_ms / 24 + $urandom_range(0, 1);
          send_tick(clock_t, 0, '0);
        end
        counted++;
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[midi_clock_tempo_tracker_core] OK");
    end else begin
      $display("[midi_clock_tempo_tracker_core] ERROR");
    end
    $finish;
  end

endmodule
